### sv/stq_pkg.sv
// Package for the sorted timer queue.
// Holds the controller state, command and status types, and the burst limit.
// No dependencies.
package stq_pkg;

  localparam int MAX_FIRE = 16;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INSERT,
    S_FIRE
  } stq_state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LATCH,
    OP_INSERT,
    OP_DROP,
    OP_POP,
    OP_POP_LAST,
    OP_REPORT
  } stq_op_t;

  typedef struct packed {
    stq_op_t op;
  } stq_cmd_t;

  typedef struct packed {
    logic full;
    logic due0;
    logic due1;
  } stq_status_t;

endpackage

### sv/sorted_timer_queue.sv
// Sorted timer queue top level: controller plus shift-register datapath.
// Insert: the beat is latched, then the result registers once the output is free; the next beat
// is taken once the controller is back in idle. Alarm: the beat is latched, then one result per
// cycle per expired handle (up to MAX_FIRE) while the output is not stalled, else one report.
// Output back-pressure holds the sequencer; one item is in work at a time.
// Synchronous reset empties the queue and disarms the alarm; entries are not cleared.
module sorted_timer_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_BITS   = 48,
  parameter int HANDLE_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   mode,
  input  logic [TIME_BITS-1:0]   time_value,
  input  logic [HANDLE_BITS-1:0] handle,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   fired_valid,
  output logic [HANDLE_BITS-1:0] fired_handle,
  output logic                   last,
  output logic                   head_valid,
  output logic [TIME_BITS-1:0]   head_time,
  output logic                   rearm,
  output logic                   insert_dropped
);

  stq_pkg::stq_cmd_t    cmd;
  stq_pkg::stq_status_t status;

  stq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .mode      (mode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  stq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_BITS   (TIME_BITS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .time_value     (time_value),
    .handle         (handle),
    .cmd            (cmd),
    .status         (status),
    .fired_valid    (fired_valid),
    .fired_handle   (fired_handle),
    .last           (last),
    .head_valid     (head_valid),
    .head_time      (head_time),
    .rearm          (rearm),
    .insert_dropped (insert_dropped)
  );

endmodule

### sv/stq_ctrl.sv
// Controller for the sorted timer queue: input handshake, sequencing, output valid.
// Depends on stq_pkg.
module stq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             mode,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  stq_pkg::stq_status_t status,
  output stq_pkg::stq_cmd_t    cmd
);

  stq_pkg::stq_state_t state, state_next;
  logic out_free;
  logic load;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != stq_pkg::S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op = stq_pkg::OP_NONE;
    case (state)
      stq_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.op = stq_pkg::OP_LATCH;
          state_next = mode ? stq_pkg::S_FIRE : stq_pkg::S_INSERT;
        end
      end
      stq_pkg::S_INSERT: begin
        if (out_free) begin
          cmd.op = status.full ? stq_pkg::OP_DROP : stq_pkg::OP_INSERT;
          state_next = stq_pkg::S_IDLE;
        end
      end
      stq_pkg::S_FIRE: begin
        if (out_free) begin
          if (status.due0 && status.due1) begin
            cmd.op = stq_pkg::OP_POP;
          end else if (status.due0) begin
            cmd.op = stq_pkg::OP_POP_LAST;
            state_next = stq_pkg::S_IDLE;
          end else begin
            cmd.op = stq_pkg::OP_REPORT;
            state_next = stq_pkg::S_IDLE;
          end
        end
      end
      default: state_next = stq_pkg::S_IDLE;
    endcase
  end

  assign load = (cmd.op inside {stq_pkg::OP_INSERT, stq_pkg::OP_DROP, stq_pkg::OP_POP,
                                stq_pkg::OP_POP_LAST, stq_pkg::OP_REPORT});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stq_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### sv/stq_datapath.sv
// Datapath for the sorted timer queue: shift-register sorted entries, alarm state,
// item latch and result register. Depends on stq_pkg.
module stq_datapath #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_BITS   = 48,
  parameter int HANDLE_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [TIME_BITS-1:0]   time_value,
  input  logic [HANDLE_BITS-1:0] handle,
  input  stq_pkg::stq_cmd_t      cmd,
  output stq_pkg::stq_status_t   status,
  output logic                   fired_valid,
  output logic [HANDLE_BITS-1:0] fired_handle,
  output logic                   last,
  output logic                   head_valid,
  output logic [TIME_BITS-1:0]   head_time,
  output logic                   rearm,
  output logic                   insert_dropped
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int FW = $clog2(stq_pkg::MAX_FIRE + 1);

  logic [TIME_BITS-1:0]   dl [QUEUE_DEPTH];
  logic [HANDLE_BITS-1:0] hd [QUEUE_DEPTH];
  logic [CW-1:0]          count;
  logic [FW-1:0]          fired;
  logic                   armed;
  logic [TIME_BITS-1:0]   armed_dl;
  logic [TIME_BITS-1:0]   t_q;
  logic [HANDLE_BITS-1:0] h_q;

  logic [QUEUE_DEPTH-1:0] m;
  logic [QUEUE_DEPTH-1:0] m_prev;
  logic [TIME_BITS-1:0]   new_head;
  logic                   ins_rearm;
  logic                   more_one;
  logic                   nonempty;

  assign nonempty = (count != '0);
  assign more_one = (count > CW'(1));

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_entry
    assign m[i] = (CW'(i) >= count) || (dl[i] >= t_q);
    if (i == 0) begin : g_first
      assign m_prev[i] = 1'b0;
    end else begin : g_rest
      assign m_prev[i] = m[i-1];
    end

    always_ff @(posedge clk) begin
      case (cmd.op)
        stq_pkg::OP_INSERT: begin
          if (m[i] && !m_prev[i]) begin
            dl[i] <= t_q;
            hd[i] <= h_q;
          end else if (m_prev[i]) begin
            dl[i] <= dl[(i == 0) ? 0 : i-1];
            hd[i] <= hd[(i == 0) ? 0 : i-1];
          end
        end
        stq_pkg::OP_POP, stq_pkg::OP_POP_LAST: begin
          if (i < QUEUE_DEPTH - 1) begin
            dl[i] <= dl[(i < QUEUE_DEPTH - 1) ? i+1 : i];
            hd[i] <= hd[(i < QUEUE_DEPTH - 1) ? i+1 : i];
          end
        end
        default: ;
      endcase
    end
  end

  assign new_head  = m[0] ? t_q : dl[0];
  assign ins_rearm = !armed || (new_head < armed_dl);

  assign status.full = (count == CW'(QUEUE_DEPTH));
  assign status.due0 = nonempty && (dl[0] <= t_q) && (fired < FW'(stq_pkg::MAX_FIRE));
  assign status.due1 = more_one && (dl[1] <= t_q) && (fired < FW'(stq_pkg::MAX_FIRE - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      fired    <= '0;
      armed    <= 1'b0;
      armed_dl <= '0;
    end else begin
      case (cmd.op)
        stq_pkg::OP_LATCH: fired <= '0;
        stq_pkg::OP_INSERT: begin
          count <= count + CW'(1);
          if (ins_rearm) begin
            armed    <= 1'b1;
            armed_dl <= new_head;
          end
        end
        stq_pkg::OP_POP: begin
          count <= count - CW'(1);
          fired <= fired + FW'(1);
        end
        stq_pkg::OP_POP_LAST: begin
          count <= count - CW'(1);
          fired <= fired + FW'(1);
          armed <= more_one;
          if (more_one) begin
            armed_dl <= dl[1];
          end
        end
        stq_pkg::OP_REPORT: begin
          armed <= nonempty;
          if (nonempty) begin
            armed_dl <= dl[0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      stq_pkg::OP_LATCH: begin
        t_q <= time_value;
        h_q <= handle;
      end
      stq_pkg::OP_INSERT: begin
        fired_valid    <= 1'b0;
        fired_handle   <= '0;
        last           <= 1'b1;
        head_valid     <= 1'b1;
        head_time      <= new_head;
        rearm          <= ins_rearm;
        insert_dropped <= 1'b0;
      end
      stq_pkg::OP_DROP: begin
        fired_valid    <= 1'b0;
        fired_handle   <= '0;
        last           <= 1'b1;
        head_valid     <= nonempty;
        head_time      <= nonempty ? dl[0] : '0;
        rearm          <= 1'b0;
        insert_dropped <= 1'b1;
      end
      stq_pkg::OP_POP: begin
        fired_valid    <= 1'b1;
        fired_handle   <= hd[0];
        last           <= 1'b0;
        head_valid     <= 1'b0;
        head_time      <= '0;
        rearm          <= 1'b0;
        insert_dropped <= 1'b0;
      end
      stq_pkg::OP_POP_LAST: begin
        fired_valid    <= 1'b1;
        fired_handle   <= hd[0];
        last           <= 1'b1;
        head_valid     <= more_one;
        head_time      <= more_one ? dl[1] : '0;
        rearm          <= more_one;
        insert_dropped <= 1'b0;
      end
      stq_pkg::OP_REPORT: begin
        fired_valid    <= 1'b0;
        fired_handle   <= '0;
        last           <= 1'b1;
        head_valid     <= nonempty;
        head_time      <= nonempty ? dl[0] : '0;
        rearm          <= nonempty;
        insert_dropped <= 1'b0;
      end
      default: ;
    endcase
  end

endmodule
